// ===== rtl/line_position_direction_core_assert.svh =====
// ----------------------------------------------------------------------------
// line_position_direction_core assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_DIRECTION_CORE_ASSERT_SVH
`define LINE_POSITION_DIRECTION_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked on every rising edge outside reset
`define LPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define LPD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LPD_ASSERT(label, clk, rst, prop, msg)
`define LPD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// shared widths, codes and types of the line position and direction core
// ----------------------------------------------------------------------------
package lpd_pkg;

   localparam int SENSOR_COUNT   = 5;
   localparam int SAMPLE_BITS    = 12;
   localparam int CNT_BITS       = 8;
   localparam int SUM_BITS       = SAMPLE_BITS + CNT_BITS;
   localparam int LIMIT_BITS     = 12;
   localparam int POS_BITS       = 12;
   localparam int DIR_BITS       = 3;
   localparam int IDX_BITS       = $clog2(SENSOR_COUNT);
   localparam int POS_STEP       = 1000;
   localparam int WEIGHT_BITS    = $clog2((SENSOR_COUNT - 1) * POS_STEP + 1);
   localparam int PROD_BITS      = SUM_BITS + WEIGHT_BITS;
   localparam int TOTAL_BITS     = SUM_BITS + $clog2(SENSOR_COUNT);
   localparam int DIV_BITS       = PROD_BITS + $clog2(SENSOR_COUNT);
   localparam int STEP_BITS      = $clog2(DIV_BITS + 1);
   localparam int ZERO_TOTAL_POS = 2000;
   localparam int POS_MAX        = 4095;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 12;

   // register reset values
   localparam int RST_WINDOW_COUNT = 3;
   localparam int RST_HARD_LEFT    = 300;
   localparam int RST_HARD_RIGHT   = 3700;
   localparam int RST_LEFT         = 1500;
   localparam int RST_RIGHT        = 2500;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_COUNT = 3'd0,
      CSR_HARD_LEFT    = 3'd1,
      CSR_HARD_RIGHT   = 3'd2,
      CSR_LEFT         = 3'd3,
      CSR_RIGHT        = 3'd4
   } csr_index_type;

   typedef enum logic [DIR_BITS-1:0] {
      DIR_STRAIGHT   = 3'd0,
      DIR_HARD_LEFT  = 3'd1,
      DIR_HARD_RIGHT = 3'd2,
      DIR_LEFT       = 3'd3,
      DIR_RIGHT      = 3'd4,
      DIR_BUTTON     = 3'd5
   } dir_type;

   // divider request and status
   typedef struct packed {
      logic                 start;
      logic [STEP_BITS-1:0] steps;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // centroid weight of a sensor: index times one thousand
   function automatic logic [WEIGHT_BITS-1:0] sensor_weight(input logic [IDX_BITS-1:0] idx);
      logic [31:0] w;
      w = 32'(idx) * 32'(POS_STEP);
      return w[WEIGHT_BITS-1:0];
   endfunction

endpackage

// ===== rtl/line_position_direction_core.sv =====
// ----------------------------------------------------------------------------
// line_position_direction_core
// windowed line-sensor averaging, weighted centroid and steering direction
// ----------------------------------------------------------------------------
// Each window opens with one frame that is dropped, then window_count frames
// are summed per sensor (a window_count of zero acts as one). Frames that do
// not close a window are summed without stalling. The frame that closes the
// window starts the result computation, which runs on one shared restoring
// divider retiring one quotient bit per cycle: each sensor is loaded, its
// average divided, multiplied by its weight and accumulated, and then the
// centroid is divided; the input stalls from the closing frame until the
// result is handed to the output register. The position is the
// sum of average times index times 1000 over the sum of averages, 2000 when
// all averages are zero, saturated at 4095. The direction code comes from
// the four limits tested in the order hard left, hard right, left, right; a
// pressed button on the closing frame forces the override code. One result
// beat leaves per window from an output register, so input frames keep being
// taken while a result waits on rsp_stall. Registers may be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module line_position_direction_core (
   input  logic                                clock,
   input  logic                                reset,

   // configuration write port
   input  logic                                csr_write,
   input  logic [lpd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lpd_pkg::CSR_DATA_BITS-1:0]   csr_data,

   // frame input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lpd_pkg::SAMPLE_BITS-1:0]     req_sensor_0,
   input  logic [lpd_pkg::SAMPLE_BITS-1:0]     req_sensor_1,
   input  logic [lpd_pkg::SAMPLE_BITS-1:0]     req_sensor_2,
   input  logic [lpd_pkg::SAMPLE_BITS-1:0]     req_sensor_3,
   input  logic [lpd_pkg::SAMPLE_BITS-1:0]     req_sensor_4,
   input  logic                                req_button_pressed,

   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lpd_pkg::POS_BITS-1:0]        rsp_position,
   output logic [lpd_pkg::DIR_BITS-1:0]        rsp_direction
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_MUL,
      ST_ACC,
      ST_POS_GO,
      ST_POS_WAIT,
      ST_DELIVER
   } state_type;

   // control state
   state_type                          state_ff, state_in;
   logic                               seed_ff, seed_in;
   logic [lpd_pkg::CNT_BITS-1:0]       frame_cnt_ff, frame_cnt_in;
   logic [lpd_pkg::IDX_BITS-1:0]       idx_ff, idx_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic [lpd_pkg::CNT_BITS-1:0]       window_count_ff, window_count_in;
   logic [lpd_pkg::LIMIT_BITS-1:0]     hard_left_ff, hard_left_in;
   logic [lpd_pkg::LIMIT_BITS-1:0]     hard_right_ff, hard_right_in;
   logic [lpd_pkg::LIMIT_BITS-1:0]     left_ff, left_in;
   logic [lpd_pkg::LIMIT_BITS-1:0]     right_ff, right_in;

   // datapath
   logic [lpd_pkg::SUM_BITS-1:0]       sums_ff [lpd_pkg::SENSOR_COUNT];
   logic [lpd_pkg::SUM_BITS-1:0]       sums_in [lpd_pkg::SENSOR_COUNT];
   logic [lpd_pkg::SUM_BITS-1:0]       avg_ff, avg_in;
   logic [lpd_pkg::PROD_BITS-1:0]      prod_ff, prod_in;
   logic [lpd_pkg::TOTAL_BITS-1:0]     total_ff, total_in;
   logic [lpd_pkg::DIV_BITS-1:0]       weighted_ff, weighted_in;
   logic                               button_ff, button_in;
   logic [lpd_pkg::POS_BITS-1:0]       pos_ff, pos_in;
   logic [lpd_pkg::POS_BITS-1:0]       rsp_position_ff, rsp_position_in;
   logic [lpd_pkg::DIR_BITS-1:0]       rsp_direction_ff, rsp_direction_in;

   // frame samples as an array, sensor i at index i
   logic [lpd_pkg::SAMPLE_BITS-1:0]    sample [lpd_pkg::SENSOR_COUNT];

   // divider hookup
   lpd_pkg::div_ctl_type               div_ctl;
   lpd_pkg::div_sts_type               div_sts;
   logic [lpd_pkg::DIV_BITS-1:0]       div_dividend;
   logic [lpd_pkg::TOTAL_BITS-1:0]     div_divisor;
   logic [lpd_pkg::DIV_BITS-1:0]       div_quotient;

   logic [lpd_pkg::CNT_BITS-1:0]       count;
   logic [lpd_pkg::CNT_BITS-1:0]       frame_cnt_next;
   logic                               req_accept;
   logic                               rsp_take;
   lpd_pkg::dir_type                   dir_sel;

   assign sample[0] = req_sensor_0;
   assign sample[1] = req_sensor_1;
   assign sample[2] = req_sensor_2;
   assign sample[3] = req_sensor_3;
   assign sample[4] = req_sensor_4;

   // frames are only taken between windows' result computations
   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;

   // zero window acts as one
   assign count          = (window_count_ff == '0) ? lpd_pkg::CNT_BITS'(1) : window_count_ff;
   assign frame_cnt_next = frame_cnt_ff + 1'b1;

   // direction from the latched position, limits in fixed order
   always_comb begin
      if (button_ff) begin
         dir_sel = lpd_pkg::DIR_BUTTON;
      end else if (pos_ff < hard_left_ff) begin
         dir_sel = lpd_pkg::DIR_HARD_LEFT;
      end else if (pos_ff > hard_right_ff) begin
         dir_sel = lpd_pkg::DIR_HARD_RIGHT;
      end else if (pos_ff < left_ff) begin
         dir_sel = lpd_pkg::DIR_LEFT;
      end else if (pos_ff > right_ff) begin
         dir_sel = lpd_pkg::DIR_RIGHT;
      end else begin
         dir_sel = lpd_pkg::DIR_STRAIGHT;
      end
   end

   // divider operands: sensor sum over the window, or weighted sum over total
   always_comb begin
      if (state_ff == ST_AVG_GO) begin
         div_dividend = {sums_ff[idx_ff], {(lpd_pkg::DIV_BITS - lpd_pkg::SUM_BITS){1'b0}}};
         div_divisor  = lpd_pkg::TOTAL_BITS'(count);
      end else begin
         div_dividend = weighted_ff;
         div_divisor  = total_ff;
      end
   end

   always_comb begin
      state_in         = state_ff;
      seed_in          = seed_ff;
      frame_cnt_in     = frame_cnt_ff;
      idx_in           = idx_ff;
      rsp_valid_in     = rsp_valid_ff;
      window_count_in  = window_count_ff;
      hard_left_in     = hard_left_ff;
      hard_right_in    = hard_right_ff;
      left_in          = left_ff;
      right_in         = right_ff;
      sums_in          = sums_ff;
      avg_in           = avg_ff;
      prod_in          = prod_ff;
      total_in         = total_ff;
      weighted_in      = weighted_ff;
      button_in        = button_ff;
      pos_in           = pos_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_direction_in = rsp_direction_ff;
      div_ctl          = '0;

      // register writes, masked to each register's width
      if (csr_write) begin
         case (csr_index)
            lpd_pkg::CSR_WINDOW_COUNT: window_count_in = csr_data[lpd_pkg::CNT_BITS-1:0];
            lpd_pkg::CSR_HARD_LEFT:    hard_left_in    = csr_data[lpd_pkg::LIMIT_BITS-1:0];
            lpd_pkg::CSR_HARD_RIGHT:   hard_right_in   = csr_data[lpd_pkg::LIMIT_BITS-1:0];
            lpd_pkg::CSR_LEFT:         left_in         = csr_data[lpd_pkg::LIMIT_BITS-1:0];
            lpd_pkg::CSR_RIGHT:        right_in        = csr_data[lpd_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      end

      // result beat leaves the output register
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (seed_ff) begin
                  // seed frame only restarts the window
                  for (int i = 0; i < lpd_pkg::SENSOR_COUNT; i++) begin
                     sums_in[i] = '0;
                  end
                  frame_cnt_in = '0;
                  seed_in      = 1'b0;
               end else begin
                  for (int i = 0; i < lpd_pkg::SENSOR_COUNT; i++) begin
                     sums_in[i] = sums_ff[i] + lpd_pkg::SUM_BITS'(sample[i]);
                  end
                  frame_cnt_in = frame_cnt_next;
                  if (frame_cnt_next >= count) begin
                     // closing frame of the window
                     button_in   = req_button_pressed;
                     idx_in      = '0;
                     total_in    = '0;
                     weighted_in = '0;
                     state_in    = ST_AVG_GO;
                  end
               end
            end
         end

         ST_AVG_GO: begin
            div_ctl.start = 1'b1;
            div_ctl.steps = lpd_pkg::STEP_BITS'(lpd_pkg::SUM_BITS);
            state_in      = ST_AVG_WAIT;
         end

         ST_AVG_WAIT: begin
            if (div_sts.done) begin
               avg_in   = div_quotient[lpd_pkg::SUM_BITS-1:0];
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            prod_in  = lpd_pkg::PROD_BITS'(avg_ff) *
                       lpd_pkg::PROD_BITS'(lpd_pkg::sensor_weight(idx_ff));
            state_in = ST_ACC;
         end

         ST_ACC: begin
            total_in    = total_ff + lpd_pkg::TOTAL_BITS'(avg_ff);
            weighted_in = weighted_ff + lpd_pkg::DIV_BITS'(prod_ff);
            if (idx_ff == lpd_pkg::IDX_BITS'(lpd_pkg::SENSOR_COUNT - 1)) begin
               state_in = ST_POS_GO;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_AVG_GO;
            end
         end

         ST_POS_GO: begin
            if (total_ff == '0) begin
               // all averages zero: centered position
               pos_in   = lpd_pkg::POS_BITS'(lpd_pkg::ZERO_TOTAL_POS);
               state_in = ST_DELIVER;
            end else begin
               div_ctl.start = 1'b1;
               div_ctl.steps = lpd_pkg::STEP_BITS'(lpd_pkg::DIV_BITS);
               state_in      = ST_POS_WAIT;
            end
         end

         ST_POS_WAIT: begin
            if (div_sts.done) begin
               if (div_quotient > lpd_pkg::DIV_BITS'(lpd_pkg::POS_MAX)) begin
                  pos_in = lpd_pkg::POS_BITS'(lpd_pkg::POS_MAX);
               end else begin
                  pos_in = div_quotient[lpd_pkg::POS_BITS-1:0];
               end
               state_in = ST_DELIVER;
            end
         end

         ST_DELIVER: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_position_in  = pos_ff;
               rsp_direction_in = dir_sel;
               seed_in          = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         seed_ff         <= 1'b1;
         frame_cnt_ff    <= '0;
         idx_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         window_count_ff <= lpd_pkg::CNT_BITS'(lpd_pkg::RST_WINDOW_COUNT);
         hard_left_ff    <= lpd_pkg::LIMIT_BITS'(lpd_pkg::RST_HARD_LEFT);
         hard_right_ff   <= lpd_pkg::LIMIT_BITS'(lpd_pkg::RST_HARD_RIGHT);
         left_ff         <= lpd_pkg::LIMIT_BITS'(lpd_pkg::RST_LEFT);
         right_ff        <= lpd_pkg::LIMIT_BITS'(lpd_pkg::RST_RIGHT);
      end else begin
         state_ff        <= state_in;
         seed_ff         <= seed_in;
         frame_cnt_ff    <= frame_cnt_in;
         idx_ff          <= idx_in;
         rsp_valid_ff    <= rsp_valid_in;
         window_count_ff <= window_count_in;
         hard_left_ff    <= hard_left_in;
         hard_right_ff   <= hard_right_in;
         left_ff         <= left_in;
         right_ff        <= right_in;
      end
      sums_ff          <= sums_in;
      avg_ff           <= avg_in;
      prod_ff          <= prod_in;
      total_ff         <= total_in;
      weighted_ff      <= weighted_in;
      button_ff        <= button_in;
      pos_ff           <= pos_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_direction_ff <= rsp_direction_in;
   end

   lpd_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctl  (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .div_sts  (div_sts),
      .quotient (div_quotient)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_direction = rsp_direction_ff;

`include "line_position_direction_core_assert.svh"

   // no frame is taken while the divider works on a window
   `LPD_ASSERT(a_stall_while_dividing, clock, reset, div_sts.busy |-> req_stall, "frame taken during divide")

   // a divide result only arrives where the sequencer waits for it
   `LPD_ASSERT(a_done_in_wait, clock, reset, div_sts.done |-> (state_ff == ST_AVG_WAIT || state_ff == ST_POS_WAIT), "divide result lost")

   // every new result beat reopens the window with a seed frame
   `LPD_ASSERT(a_seed_after_result, clock, reset, $rose(rsp_valid_ff) |-> seed_ff, "window not reseeded")

endmodule

// ===== rtl/lpd_serial_div.sv =====
// ----------------------------------------------------------------------------
// lpd_serial_div
// restoring divider, one quotient bit per cycle, programmable step count
// ----------------------------------------------------------------------------
module lpd_serial_div (
   input  logic                            clock,
   input  logic                            reset,
   input  lpd_pkg::div_ctl_type            div_ctl,
   input  logic [lpd_pkg::DIV_BITS-1:0]    dividend,
   input  logic [lpd_pkg::TOTAL_BITS-1:0]  divisor,
   output lpd_pkg::div_sts_type            div_sts,
   output logic [lpd_pkg::DIV_BITS-1:0]    quotient
);

   // dividend is left aligned: the first step takes its top bit
   logic [lpd_pkg::DIV_BITS-1:0]   dvd_ff, dvd_in;
   logic [lpd_pkg::DIV_BITS-1:0]   quo_ff, quo_in;
   logic [lpd_pkg::TOTAL_BITS-1:0] dsr_ff, dsr_in;
   logic [lpd_pkg::TOTAL_BITS-1:0] rem_ff, rem_in;
   logic [lpd_pkg::STEP_BITS-1:0]  cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [lpd_pkg::TOTAL_BITS:0]   trial;
   logic [lpd_pkg::TOTAL_BITS:0]   diff;
   logic                           fits;

   always_comb begin
      trial  = {rem_ff, dvd_ff[lpd_pkg::DIV_BITS-1]};
      diff   = trial - {1'b0, dsr_ff};
      fits   = (trial >= {1'b0, dsr_ff});

      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (div_ctl.start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = div_ctl.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[lpd_pkg::TOTAL_BITS-1:0] : trial[lpd_pkg::TOTAL_BITS-1:0];
         dvd_in = {dvd_ff[lpd_pkg::DIV_BITS-2:0], 1'b0};
         quo_in = {quo_ff[lpd_pkg::DIV_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == lpd_pkg::STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign div_sts.busy = busy_ff;
   assign div_sts.done = done_ff;
   assign quotient     = quo_ff;

endmodule
